### rtl/crth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crth_pkg
// Shared types, constants and the micro-program of the ray/triangle core.
// ----------------------------------------------------------------------------
package crth_pkg;

  localparam int MAX_TRI = 1024;
  localparam int VDEPTH  = 3 * MAX_TRI;
  localparam int VA_W    = $clog2(VDEPTH);
  localparam int TC_W    = $clog2(MAX_TRI + 1);
  localparam int ACC_W   = 52;
  localparam int RF_N    = 29;

  // Operation codes on the input channel.
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SCALE_X = 3'd0;
  localparam logic [2:0] REG_SCALE_Y = 3'd1;
  localparam logic [2:0] REG_SCALE_Z = 3'd2;
  localparam logic [2:0] REG_POS_X   = 3'd3;
  localparam logic [2:0] REG_POS_Y   = 3'd4;
  localparam logic [2:0] REG_POS_Z   = 3'd5;

  // Operand codes: codes below 32 address the working register file.
  localparam logic [5:0] R_P0X = 6'd0,  R_P0Y = 6'd1,  R_P0Z = 6'd2;
  localparam logic [5:0] R_P1X = 6'd3,  R_P1Y = 6'd4,  R_P1Z = 6'd5;
  localparam logic [5:0] R_P2X = 6'd6,  R_P2Y = 6'd7,  R_P2Z = 6'd8;
  localparam logic [5:0] R_E1X = 6'd9,  R_E1Y = 6'd10, R_E1Z = 6'd11;
  localparam logic [5:0] R_E2X = 6'd12, R_E2Y = 6'd13, R_E2Z = 6'd14;
  localparam logic [5:0] R_SX  = 6'd15, R_SY  = 6'd16, R_SZ  = 6'd17;
  localparam logic [5:0] R_HX  = 6'd18, R_HY  = 6'd19, R_HZ  = 6'd20;
  localparam logic [5:0] R_QX  = 6'd21, R_QY  = 6'd22, R_QZ  = 6'd23;
  localparam logic [5:0] R_DET = 6'd24, R_NUM = 6'd25;
  localparam logic [5:0] R_PTX = 6'd26, R_PTY = 6'd27, R_PTZ = 6'd28;
  localparam logic [5:0] X_ONE  = 6'd32, X_ZERO = 6'd33;
  localparam logic [5:0] X_SCX  = 6'd34, X_SCY  = 6'd35, X_SCZ = 6'd36;
  localparam logic [5:0] X_POSX = 6'd37, X_POSY = 6'd38, X_POSZ = 6'd39;
  localparam logic [5:0] X_ORX  = 6'd40, X_ORY  = 6'd41, X_ORZ = 6'd42;
  localparam logic [5:0] X_DRX  = 6'd43, X_DRY  = 6'd44, X_DRZ = 6'd45;
  localparam logic [5:0] X_VTX  = 6'd46, X_VTY  = 6'd47, X_VTZ = 6'd48;
  localparam logic [5:0] X_BEST = 6'd49;

  // Quotient targets of a divide step.
  localparam logic [1:0] DV_U = 2'd0;
  localparam logic [1:0] DV_V = 2'd1;
  localparam logic [1:0] DV_T = 2'd2;

  localparam logic [5:0] PC_TRI_END = 6'd57;
  localparam logic [5:0] PC_HIT     = 6'd58;

  typedef enum logic [1:0] {K_MAC, K_READ, K_DIV, K_END} uop_kind_t;

  typedef struct packed {
    uop_kind_t  kind;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] c;
    logic       neg;
    logic       first;
    logic       last;
    logic [4:0] dest;
    logic [1:0] sel;
  } uop_t;

  function automatic uop_t mac(input logic [5:0] a, input logic [5:0] b,
                               input logic [5:0] c, input logic neg,
                               input logic first, input logic last,
                               input logic [5:0] dest);
    uop_t u;
    u       = '0;
    u.kind  = K_MAC;
    u.a     = a;
    u.b     = b;
    u.c     = c;
    u.neg   = neg;
    u.first = first;
    u.last  = last;
    u.dest  = dest[4:0];
    return u;
  endfunction

  function automatic uop_t ctl(input uop_kind_t kind, input logic [1:0] sel);
    uop_t u;
    u      = '0;
    u.kind = kind;
    u.sel  = sel;
    return u;
  endfunction

  // Micro-program. Steps 0 to 57 test one triangle, 58 onwards form the
  // hit point from the closest t.
  function automatic uop_t crth_uop(input logic [5:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = ctl(K_READ, 2'd0);
      6'd1:  u = mac(X_VTX, X_SCX, X_POSX, 1'b0, 1'b1, 1'b1, R_P0X);
      6'd2:  u = mac(X_VTY, X_SCY, X_POSY, 1'b0, 1'b1, 1'b1, R_P0Y);
      6'd3:  u = mac(X_VTZ, X_SCZ, X_POSZ, 1'b0, 1'b1, 1'b1, R_P0Z);
      6'd4:  u = ctl(K_READ, 2'd1);
      6'd5:  u = mac(X_VTX, X_SCX, X_POSX, 1'b0, 1'b1, 1'b1, R_P1X);
      6'd6:  u = mac(X_VTY, X_SCY, X_POSY, 1'b0, 1'b1, 1'b1, R_P1Y);
      6'd7:  u = mac(X_VTZ, X_SCZ, X_POSZ, 1'b0, 1'b1, 1'b1, R_P1Z);
      6'd8:  u = ctl(K_READ, 2'd2);
      6'd9:  u = mac(X_VTX, X_SCX, X_POSX, 1'b0, 1'b1, 1'b1, R_P2X);
      6'd10: u = mac(X_VTY, X_SCY, X_POSY, 1'b0, 1'b1, 1'b1, R_P2Y);
      6'd11: u = mac(X_VTZ, X_SCZ, X_POSZ, 1'b0, 1'b1, 1'b1, R_P2Z);
      6'd12: u = mac(R_P1X, X_ONE, X_ZERO, 1'b0, 1'b1, 1'b0, R_E1X);
      6'd13: u = mac(R_P0X, X_ONE, X_ZERO, 1'b1, 1'b0, 1'b1, R_E1X);
      6'd14: u = mac(R_P1Y, X_ONE, X_ZERO, 1'b0, 1'b1, 1'b0, R_E1Y);
      6'd15: u = mac(R_P0Y, X_ONE, X_ZERO, 1'b1, 1'b0, 1'b1, R_E1Y);
      6'd16: u = mac(R_P1Z, X_ONE, X_ZERO, 1'b0, 1'b1, 1'b0, R_E1Z);
      6'd17: u = mac(R_P0Z, X_ONE, X_ZERO, 1'b1, 1'b0, 1'b1, R_E1Z);
      6'd18: u = mac(R_P2X, X_ONE, X_ZERO, 1'b0, 1'b1, 1'b0, R_E2X);
      6'd19: u = mac(R_P0X, X_ONE, X_ZERO, 1'b1, 1'b0, 1'b1, R_E2X);
      6'd20: u = mac(R_P2Y, X_ONE, X_ZERO, 1'b0, 1'b1, 1'b0, R_E2Y);
      6'd21: u = mac(R_P0Y, X_ONE, X_ZERO, 1'b1, 1'b0, 1'b1, R_E2Y);
      6'd22: u = mac(R_P2Z, X_ONE, X_ZERO, 1'b0, 1'b1, 1'b0, R_E2Z);
      6'd23: u = mac(R_P0Z, X_ONE, X_ZERO, 1'b1, 1'b0, 1'b1, R_E2Z);
      6'd24: u = mac(X_ORX, X_ONE, X_ZERO, 1'b0, 1'b1, 1'b0, R_SX);
      6'd25: u = mac(R_P0X, X_ONE, X_ZERO, 1'b1, 1'b0, 1'b1, R_SX);
      6'd26: u = mac(X_ORY, X_ONE, X_ZERO, 1'b0, 1'b1, 1'b0, R_SY);
      6'd27: u = mac(R_P0Y, X_ONE, X_ZERO, 1'b1, 1'b0, 1'b1, R_SY);
      6'd28: u = mac(X_ORZ, X_ONE, X_ZERO, 1'b0, 1'b1, 1'b0, R_SZ);
      6'd29: u = mac(R_P0Z, X_ONE, X_ZERO, 1'b1, 1'b0, 1'b1, R_SZ);
      6'd30: u = mac(X_DRY, R_E2Z, X_ZERO, 1'b0, 1'b1, 1'b0, R_HX);
      6'd31: u = mac(X_DRZ, R_E2Y, X_ZERO, 1'b1, 1'b0, 1'b1, R_HX);
      6'd32: u = mac(X_DRZ, R_E2X, X_ZERO, 1'b0, 1'b1, 1'b0, R_HY);
      6'd33: u = mac(X_DRX, R_E2Z, X_ZERO, 1'b1, 1'b0, 1'b1, R_HY);
      6'd34: u = mac(X_DRX, R_E2Y, X_ZERO, 1'b0, 1'b1, 1'b0, R_HZ);
      6'd35: u = mac(X_DRY, R_E2X, X_ZERO, 1'b1, 1'b0, 1'b1, R_HZ);
      6'd36: u = mac(R_E1X, R_HX, X_ZERO, 1'b0, 1'b1, 1'b0, R_DET);
      6'd37: u = mac(R_E1Y, R_HY, X_ZERO, 1'b0, 1'b0, 1'b0, R_DET);
      6'd38: u = mac(R_E1Z, R_HZ, X_ZERO, 1'b0, 1'b0, 1'b1, R_DET);
      6'd39: u = mac(R_SX, R_HX, X_ZERO, 1'b0, 1'b1, 1'b0, R_NUM);
      6'd40: u = mac(R_SY, R_HY, X_ZERO, 1'b0, 1'b0, 1'b0, R_NUM);
      6'd41: u = mac(R_SZ, R_HZ, X_ZERO, 1'b0, 1'b0, 1'b1, R_NUM);
      6'd42: u = ctl(K_DIV, DV_U);
      6'd43: u = mac(R_SY, R_E1Z, X_ZERO, 1'b0, 1'b1, 1'b0, R_QX);
      6'd44: u = mac(R_SZ, R_E1Y, X_ZERO, 1'b1, 1'b0, 1'b1, R_QX);
      6'd45: u = mac(R_SZ, R_E1X, X_ZERO, 1'b0, 1'b1, 1'b0, R_QY);
      6'd46: u = mac(R_SX, R_E1Z, X_ZERO, 1'b1, 1'b0, 1'b1, R_QY);
      6'd47: u = mac(R_SX, R_E1Y, X_ZERO, 1'b0, 1'b1, 1'b0, R_QZ);
      6'd48: u = mac(R_SY, R_E1X, X_ZERO, 1'b1, 1'b0, 1'b1, R_QZ);
      6'd49: u = mac(X_DRX, R_QX, X_ZERO, 1'b0, 1'b1, 1'b0, R_NUM);
      6'd50: u = mac(X_DRY, R_QY, X_ZERO, 1'b0, 1'b0, 1'b0, R_NUM);
      6'd51: u = mac(X_DRZ, R_QZ, X_ZERO, 1'b0, 1'b0, 1'b1, R_NUM);
      6'd52: u = ctl(K_DIV, DV_V);
      6'd53: u = mac(R_E2X, R_QX, X_ZERO, 1'b0, 1'b1, 1'b0, R_NUM);
      6'd54: u = mac(R_E2Y, R_QY, X_ZERO, 1'b0, 1'b0, 1'b0, R_NUM);
      6'd55: u = mac(R_E2Z, R_QZ, X_ZERO, 1'b0, 1'b0, 1'b1, R_NUM);
      6'd56: u = ctl(K_DIV, DV_T);
      6'd58: u = mac(X_DRX, X_BEST, X_ORX, 1'b0, 1'b1, 1'b1, R_PTX);
      6'd59: u = mac(X_DRY, X_BEST, X_ORY, 1'b0, 1'b1, 1'b1, R_PTY);
      6'd60: u = mac(X_DRZ, X_BEST, X_ORZ, 1'b0, 1'b1, 1'b1, R_PTZ);
      default: u = ctl(K_END, 2'd0);
    endcase
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(64'sh7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -ACC_W'(64'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/closest_ray_triangle_hit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_ray_triangle_hit_core
// Triangle mesh store with a closest-hit ray query (Moller-Trumbore, Q16.16).
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                Payload
//  -------   ----------------------   -----------------------------------------
//  input     in_valid / in_ready      op, a_x, a_y, a_z, dir_x, dir_y, dir_z
//  output    out_valid / out_ready    hit, hit_t, hit_x, hit_y, hit_z
//  config    cfg_we (no handshake)    cfg_index, cfg_data
//
//  An append or clear transaction completes as it is taken. A query visits
//  every stored triangle in turn: the single 32x32 multiplier forms the
//  product and then accumulates it on each of 51 multiply-accumulate steps,
//  the three vertex reads come from the store, and the radix-2 divider holds
//  the sequencer on each of the u, v and t quotients while it forms 48
//  quotient bits. The block accepts nothing while a query runs. A finished
//  result waits in the output register; further
//  transactions are still taken while it waits, and a query that finishes
//  meanwhile holds the sequencer until the register is free again.
//  Reset clears the control state and registers only; the vertex store has no
//  clearing pass, as only written entries are ever read.
//
module closest_ray_triangle_hit_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic signed [31:0] hit_t,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic signed [31:0] hit_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_DONE} state_t;

  state_t state;

  // Configuration registers.
  logic signed [31:0] scale_x, scale_y, scale_z;
  logic signed [31:0] position_x, position_y, position_z;

  // Mesh bookkeeping.
  logic [crth_pkg::TC_W-1:0] tri_count;
  logic [1:0]                phase;

  // Vertex store: x, y and z of one vertex share a word.
  logic [95:0]               vmem [crth_pkg::VDEPTH];
  logic [95:0]               vq;
  logic [crth_pkg::VA_W-1:0] wr_addr;
  logic [crth_pkg::VA_W-1:0] rd_addr;
  logic                      wr_en;
  logic                      rd_en;

  // Query sequencer.
  logic [5:0]                pc;
  logic                      sub;
  logic [crth_pkg::TC_W-1:0] tri_idx;
  logic [crth_pkg::VA_W-1:0] base;
  logic                      found;
  logic signed [31:0]        best;
  logic signed [31:0]        ox, oy, oz, dx, dy, dz;
  logic signed [31:0]        u_r, v_r, t_r;
  logic signed [31:0]        rf [crth_pkg::RF_N];
  crth_pkg::uop_t            uop;

  // Shared datapath.
  logic signed [63:0]              prod;
  logic signed [crth_pkg::ACC_W-1:0] acc;
  logic signed [crth_pkg::ACC_W-1:0] acc_base;
  logic signed [crth_pkg::ACC_W-1:0] acc_sum;
  logic signed [47:0]              term;
  logic signed [31:0]              opa, opb, opc;

  logic                div_start;
  logic                div_done;
  logic signed [31:0]  div_q;
  logic signed [32:0]  uv_sum;
  logic                tri_ok;
  logic                take;
  logic                found_next;

  // Operand selection: file registers below code 32, everything else by name.
  function automatic logic signed [31:0] opnd(input logic [5:0] code);
    logic signed [31:0] r;
    if (!code[5]) begin
      r = rf[code[4:0]];
    end else begin
      case (code)
        crth_pkg::X_ONE:  r = 32'sd65536;
        crth_pkg::X_SCX:  r = scale_x;
        crth_pkg::X_SCY:  r = scale_y;
        crth_pkg::X_SCZ:  r = scale_z;
        crth_pkg::X_POSX: r = position_x;
        crth_pkg::X_POSY: r = position_y;
        crth_pkg::X_POSZ: r = position_z;
        crth_pkg::X_ORX:  r = ox;
        crth_pkg::X_ORY:  r = oy;
        crth_pkg::X_ORZ:  r = oz;
        crth_pkg::X_DRX:  r = dx;
        crth_pkg::X_DRY:  r = dy;
        crth_pkg::X_DRZ:  r = dz;
        crth_pkg::X_VTX:  r = vq[31:0];
        crth_pkg::X_VTY:  r = vq[63:32];
        crth_pkg::X_VTZ:  r = vq[95:64];
        crth_pkg::X_BEST: r = best;
        default:          r = '0;
      endcase
    end
    return r;
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign uop      = crth_pkg::crth_uop(pc);

  // The operands follow the registers they name as well as the step code.
  always_comb begin
    opa = opnd(uop.a);
    opb = opnd(uop.b);
    opc = opnd(uop.c);
  end

  // Product is floored by the arithmetic shift; the first term of a sum
  // starts from the addend operand.
  assign term     = prod[63:16];
  assign acc_base = uop.first ? crth_pkg::ACC_W'(opc) : acc;
  assign acc_sum  = uop.neg ? (acc_base - crth_pkg::ACC_W'(term))
                            : (acc_base + crth_pkg::ACC_W'(term));

  // Append address: triangle_count * 3 + phase.
  assign wr_addr = crth_pkg::VA_W'({tri_count, 1'b0} + tri_count + phase);
  assign wr_en   = in_valid && in_ready && (op == crth_pkg::OP_APPEND)
                   && (tri_count != crth_pkg::TC_W'(crth_pkg::MAX_TRI));
  assign rd_addr = base + crth_pkg::VA_W'(uop.sel);
  assign rd_en   = (state == ST_RUN) && (uop.kind == crth_pkg::K_READ);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[wr_addr] <= {a_z, a_y, a_x};
    end
    if (rd_en) begin
      vq <= vmem[rd_addr];
    end
  end

  // Acceptance test of the triangle just finished.
  assign uv_sum     = 33'(u_r) + 33'(v_r);
  assign tri_ok     = (rf[crth_pkg::R_DET[4:0]] != 32'sd0) && !u_r[31]
                      && (u_r <= 32'sd65536) && !v_r[31]
                      && (uv_sum <= 33'sd65536) && (t_r > 32'sd0);
  assign take       = tri_ok && (!found || (t_r < best));
  assign found_next = found || tri_ok;

  assign div_start = (state == ST_RUN) && (uop.kind == crth_pkg::K_DIV);

  crth_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rf[crth_pkg::R_NUM[4:0]]),
    .den   (rf[crth_pkg::R_DET[4:0]]),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      tri_count  <= '0;
      phase      <= '0;
      found      <= 1'b0;
      pc         <= '0;
      sub        <= 1'b0;
      scale_x    <= 32'sd655360;
      scale_y    <= 32'sd655360;
      scale_z    <= 32'sd655360;
      position_x <= 32'sd0;
      position_y <= 32'sd0;
      position_z <= 32'sd327680;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          crth_pkg::REG_SCALE_X: scale_x    <= cfg_data;
          crth_pkg::REG_SCALE_Y: scale_y    <= cfg_data;
          crth_pkg::REG_SCALE_Z: scale_z    <= cfg_data;
          crth_pkg::REG_POS_X:   position_x <= cfg_data;
          crth_pkg::REG_POS_Y:   position_y <= cfg_data;
          crth_pkg::REG_POS_Z:   position_z <= cfg_data;
          default: ;
        endcase
      end

      // In the done state the output register is handled by that state alone.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ox <= a_x;
            oy <= a_y;
            oz <= a_z;
            dx <= dir_x;
            dy <= dir_y;
            dz <= dir_z;
            case (op)
              crth_pkg::OP_APPEND: begin
                // A full mesh drops the vertex and keeps the phase.
                if (tri_count != crth_pkg::TC_W'(crth_pkg::MAX_TRI)) begin
                  if (phase == 2'd2) begin
                    phase     <= '0;
                    tri_count <= tri_count + 1'b1;
                  end else begin
                    phase <= phase + 2'd1;
                  end
                end
              end
              crth_pkg::OP_QUERY: begin
                found   <= 1'b0;
                best    <= '0;
                tri_idx <= '0;
                base    <= '0;
                pc      <= '0;
                sub     <= 1'b0;
                state   <= (tri_count == '0) ? ST_DONE : ST_RUN;
              end
              crth_pkg::OP_CLEAR: begin
                tri_count <= '0;
                phase     <= '0;
              end
              default: ;
            endcase
          end
        end

        ST_RUN: begin
          case (uop.kind)
            crth_pkg::K_READ: begin
              pc <= pc + 6'd1;
            end
            crth_pkg::K_MAC: begin
              if (!sub) begin
                prod <= 64'(opa) * 64'(opb);
                sub  <= 1'b1;
              end else begin
                acc <= acc_sum;
                if (uop.last) begin
                  rf[uop.dest] <= crth_pkg::sat32(acc_sum);
                end
                sub <= 1'b0;
                pc  <= pc + 6'd1;
              end
            end
            crth_pkg::K_DIV: begin
              state <= ST_DIV;
            end
            default: begin
              if (pc == crth_pkg::PC_TRI_END) begin
                if (take) begin
                  found <= 1'b1;
                  best  <= t_r;
                end
                if (tri_idx + 1'b1 == tri_count) begin
                  if (found_next) begin
                    pc <= crth_pkg::PC_HIT;
                  end else begin
                    state <= ST_DONE;
                  end
                end else begin
                  tri_idx <= tri_idx + 1'b1;
                  base    <= base + crth_pkg::VA_W'(3);
                  pc      <= '0;
                end
              end else begin
                state <= ST_DONE;
              end
            end
          endcase
        end

        ST_DIV: begin
          if (div_done) begin
            case (uop.sel)
              crth_pkg::DV_U: u_r <= div_q;
              crth_pkg::DV_V: v_r <= div_q;
              default:        t_r <= div_q;
            endcase
            pc    <= pc + 6'd1;
            state <= ST_RUN;
          end
        end

        default: begin
          // Result goes out once the output register is free.
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            hit       <= found;
            hit_t     <= found ? best : 32'sd0;
            hit_x     <= found ? rf[crth_pkg::R_PTX[4:0]] : 32'sd0;
            hit_y     <= found ? rf[crth_pkg::R_PTY[4:0]] : 32'sd0;
            hit_z     <= found ? rf[crth_pkg::R_PTZ[4:0]] : 32'sd0;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

### rtl/crth_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crth_div
// Radix-2 restoring divider: (num * 65536) / den, truncated toward zero and
// saturated to 32 bits. One quotient bit per cycle, 48 quotient bits a division.
// ----------------------------------------------------------------------------
module crth_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  logic        busy;
  logic [5:0]  cnt;
  logic [47:0] nq;
  logic [32:0] rem;
  logic [31:0] dmag;
  logic        neg;
  logic [32:0] rem_sh;
  logic        qbit;

  assign rem_sh = {rem[31:0], nq[47]};
  assign qbit   = (rem_sh >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nq   <= {(num[31] ? 32'(-num) : 32'(num)), 16'b0};
        dmag <= den[31] ? 32'(-den) : 32'(den);
        neg  <= num[31] ^ den[31];
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= qbit ? (rem_sh - {1'b0, dmag}) : rem_sh;
        nq  <= {nq[46:0], qbit};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign and saturation of the magnitude held in nq.
  always_comb begin
    if (neg) begin
      quo = (nq > 48'h8000_0000) ? 32'sh8000_0000 : 32'(-nq);
    end else begin
      quo = (nq > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(nq);
    end
  end

endmodule

### rtl/crth_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crth_check
// Port-level assertions for the ray/triangle core, bound to the top level.
// ----------------------------------------------------------------------------
module crth_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         op,
  input logic               out_valid,
  input logic               out_ready,
  input logic               hit,
  input logic signed [31:0] hit_t,
  input logic signed [31:0] hit_x,
  input logic signed [31:0] hit_y,
  input logic signed [31:0] hit_z
);

  // A miss reports zeros everywhere.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_t == 0 && hit_x == 0 && hit_y == 0 && hit_z == 0)
    else $error("miss transaction carries non-zero fields");

  // A reported hit lies strictly ahead of the origin.
  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> hit_t > 0)
    else $error("hit with non-positive t");

  // A query keeps the input side closed in the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == crth_pkg::OP_QUERY |=> !in_ready)
    else $error("input taken straight after a query");

  // A waiting result holds its hit flag and its t.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_t) && $stable(hit))
    else $error("result changed while stalled");

  // Nothing is offered straight after reset.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind closest_ray_triangle_hit_core crth_check u_crth_check (.*);
